### design/pps_pkg.sv
package pps_pkg;

  localparam int HeapDepth = 64;
  localparam int IdxW      = $clog2(HeapDepth);
  localparam int CntW      = $clog2(HeapDepth + 1);

  localparam logic [1:0] StAccepted = 2'd0;
  localparam logic [1:0] StDropped  = 2'd1;
  localparam logic [1:0] StRan      = 2'd2;
  localparam logic [1:0] StIdle     = 2'd3;

  // One heap slot: pid, priority, remaining, original burst, arrival, responded.
  typedef struct packed {
    logic [7:0]  pid;
    logic [7:0]  prio;
    logic [15:0] remaining;
    logic [15:0] orig;
    logic [31:0] arrival;
    logic        responded;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

endpackage

### design/preemptive_priority_scheduler_unit.sv
// Channel   Direction  Contents
// s_axis    in         tdata: action, pid, priority_req, burst
// m_axis    out        tdata: status, run_pid, tick_time, first_run, response_time,
//                      finished, turnaround, waiting
//
// An accepted arrival sifts up level by level; a tick serves the root, sifts the last
// slot down and sifts the served slot up again if work is left. Both are paced by the
// single-port heap memory with registered read and the one shared priority comparator.
// Reset clears the state, the count, the time and the valid flags.
// A finished request waits for the output register; a stalled result holds only that.
module preemptive_priority_scheduler_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[0], pid[8:1], priority_req[16:9], burst[32:17], zero fill to 40 bits
  input  logic [39:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], run_pid[9:2], tick_time[41:10], first_run[42],
  // response_time[74:43], finished[75], turnaround[107:76], waiting[139:108]
  output logic [143:0] m_axis_tdata
);
  import pps_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UPRD   = 4'd1;
  localparam logic [3:0] S_UPCMP  = 4'd2;
  localparam logic [3:0] S_POPTOP = 4'd3;
  localparam logic [3:0] S_LASTRD = 4'd4;
  localparam logic [3:0] S_DNL    = 4'd5;
  localparam logic [3:0] S_DNR    = 4'd6;
  localparam logic [3:0] S_DNCMP  = 4'd7;
  localparam logic [3:0] S_REQ    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  // Heap memory, one port, registered read.
  slot_t heap_mem [HeapDepth];
  slot_t rd_q;
  logic            we;
  logic [IdxW-1:0] addr;
  slot_t           wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[addr] <= wdata;
    end
    rd_q <= heap_mem[addr];
  end

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     time_q, time_d;
  logic [IdxW-1:0] i_q, i_d;       // current position of the moving slot
  logic [IdxW-1:0] c_q, c_d;       // chosen child during sift-down
  slot_t           mv_q, mv_d;     // moving slot
  slot_t           cs_q, cs_d;     // smaller of the moving slot and the left child
  slot_t           rq_q, rq_d;     // served slot waiting to be queued again
  logic            rq_v_q, rq_v_d;
  logic            has_c_q, has_c_d;
  logic [143:0]    res_q, res_d;   // result being built
  logic            out_v_q, out_v_d;
  logic [143:0]    out_q, out_d;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  logic [IdxW:0] l_full, r_full;
  assign l_full = {i_q, 1'b1};
  assign r_full = {i_q, 1'b0} + (IdxW + 1)'(2);

  logic [IdxW-1:0] parent;
  assign parent = (i_q - 1'b1) >> 1;

  // Time since arrival, counted to the end of the current tick.
  logic [31:0] span;
  assign span = time_q - rd_q.arrival;

  // The one priority comparator, its operands chosen by the state.
  logic [7:0] cmp_a, cmp_b;
  logic       cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    cmp_a = rd_q.prio;
    cmp_b = mv_q.prio;
    if (state_q == S_UPCMP) begin
      cmp_a = mv_q.prio;
      cmp_b = rd_q.prio;
    end else if (state_q == S_DNCMP) begin
      cmp_b = cs_q.prio;
    end
  end

  // Sequencer over the shared memory port and the comparator.
  always_comb begin
    state_d = state_q; count_d = count_q; time_d = time_q;
    i_d = i_q; c_d = c_q; mv_d = mv_q; cs_d = cs_q; has_c_d = has_c_q;
    rq_d = rq_q; rq_v_d = rq_v_q; res_d = res_q;
    out_v_d = out_v_q; out_d = out_q;
    we = 1'b0; addr = i_q; wdata = mv_q;
    if (m_axis_tvalid && m_axis_tready) out_v_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          res_d = '0;
          res_d[41:10] = time_q;
          if (!s_axis_tdata[0]) begin
            res_d[9:2] = s_axis_tdata[8:1];
            if (count_q >= CntW'(HeapDepth)) begin
              res_d[1:0] = StDropped;
              state_d = S_OUT;
            end else begin
              res_d[1:0] = StAccepted;
              mv_d = '{pid: s_axis_tdata[8:1], prio: s_axis_tdata[16:9],
                       remaining: s_axis_tdata[32:17], orig: s_axis_tdata[32:17],
                       arrival: time_q, responded: 1'b0};
              i_d = count_q[IdxW-1:0];
              count_d = count_q + 1'b1;
              state_d = S_UPRD;
            end
          end else begin
            time_d = time_q + 32'd1;
            if (count_q == '0) begin
              res_d[1:0] = StIdle;
              state_d = S_OUT;
            end else begin
              res_d[1:0] = StRan;
              addr = '0;
              state_d = S_POPTOP;
            end
          end
        end
      end
      // Sift-up: settle at the root, or read the parent.
      S_UPRD: begin
        if (i_q == '0) begin
          we = 1'b1; addr = i_q; wdata = mv_q;
          state_d = S_OUT;
        end else begin
          addr = parent;
          state_d = S_UPCMP;
        end
      end
      // A strictly greater parent moves down into the hole; otherwise settle here.
      S_UPCMP: begin
        we = 1'b1; addr = i_q;
        if (cmp_lt) begin
          wdata = rd_q;
          i_d = parent;
          state_d = S_UPRD;
        end else begin
          wdata = mv_q;
          state_d = S_OUT;
        end
      end
      // The root has been read: serve it and read the last slot.
      S_POPTOP: begin
        res_d[9:2] = rd_q.pid;
        if (!rd_q.responded) begin
          res_d[42] = 1'b1;
          res_d[74:43] = span - 32'd1;
        end
        rq_d = rd_q;
        rq_d.responded = 1'b1;
        rq_d.remaining = rd_q.remaining - 16'd1;
        if (rd_q.remaining <= 16'd1) begin
          res_d[75] = 1'b1;
          res_d[107:76] = span;
          res_d[139:108] = span - {16'd0, rd_q.orig};
          rq_v_d = 1'b0;
        end else begin
          rq_v_d = 1'b1;
        end
        count_d = count_q - 1'b1;
        addr = IdxW'(count_q - 1'b1);
        if (count_q == CntW'(1)) begin
          state_d = S_REQ;
        end else begin
          state_d = S_LASTRD;
        end
      end
      // The last slot starts its sift-down from the root.
      S_LASTRD: begin
        mv_d = rd_q;
        i_d = '0;
        state_d = S_DNL;
      end
      S_DNL: begin
        if (CntW'(l_full) < count_q) begin
          addr = l_full[IdxW-1:0];
          state_d = S_DNR;
        end else begin
          we = 1'b1; addr = i_q; wdata = mv_q;
          state_d = S_REQ;
        end
      end
      // Left child read: it wins only when strictly smaller than the moving slot.
      S_DNR: begin
        if (cmp_lt) begin
          cs_d = rd_q;
          c_d = l_full[IdxW-1:0];
          has_c_d = 1'b1;
        end else begin
          cs_d = mv_q;
          has_c_d = 1'b0;
        end
        addr = r_full[IdxW-1:0];
        state_d = S_DNCMP;
      end
      // Right child read: it wins only when strictly smaller than the best so far.
      S_DNCMP: begin
        we = 1'b1; addr = i_q;
        if (CntW'(r_full) < count_q && cmp_lt) begin
          wdata = rd_q;
          i_d = r_full[IdxW-1:0];
          state_d = S_DNL;
        end else if (has_c_q) begin
          wdata = cs_q;
          i_d = c_q;
          state_d = S_DNL;
        end else begin
          wdata = mv_q;
          state_d = S_REQ;
        end
      end
      // Queue the served process again if work is left.
      S_REQ: begin
        if (rq_v_q) begin
          mv_d = rq_q;
          i_d = count_q[IdxW-1:0];
          count_d = count_q + 1'b1;
          rq_v_d = 1'b0;
          state_d = S_UPRD;
        end else begin
          state_d = S_OUT;
        end
      end
      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d = 1'b1;
          out_d = res_q;
          state_d = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      time_q  <= '0;
      out_v_q <= 1'b0;
      rq_v_q  <= 1'b0;
      has_c_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      time_q  <= time_d;
      out_v_q <= out_v_d;
      rq_v_q  <= rq_v_d;
      has_c_q <= has_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; c_q <= c_d; mv_q <= mv_d; cs_q <= cs_d; rq_q <= rq_d;
    res_q <= res_d; out_q <= out_d;
  end

endmodule

### verif/preemptive_priority_scheduler_unit_tb.sv
module preemptive_priority_scheduler_unit_tb;
  import pps_pkg::*;

  localparam int ActArrive = 0;
  localparam int ActTick   = 1;

  // Fields from the highest bit down, so that status lands in the lowest bits.
  typedef struct packed {
    logic [31:0] waiting;
    logic [31:0] turnaround;
    logic        finished;
    logic [31:0] response_time;
    logic        first_run;
    logic [31:0] tick_time;
    logic [7:0]  run_pid;
    logic [1:0]  status;
  } sched_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;

  // Requests waiting to be driven and results still due.
  logic [39:0]   request_queue[$];
  sched_result_t due_results[$];

  // Predictor state.
  slot_t       ready_heap[HeapDepth];
  int unsigned ready_count;
  logic [31:0] sched_time;

  int          error_count;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  bit          stimulus_done;

  // Acceptance seen at the last rising edge, so the driver can move on.
  logic s_axis_tready_q;

  preemptive_priority_scheduler_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = ~clk_i;
  end

  // Insert a slot into the ready heap, sifting up on a strictly greater parent.
  task automatic heap_insert(input slot_t s);
    int unsigned i;
    int unsigned up;
    slot_t       tmp;
    i = ready_count;
    ready_heap[i] = s;
    ready_count++;
    while (i != 0) begin
      up = (i - 1) / 2;
      if (!(ready_heap[up].prio > ready_heap[i].prio)) break;
      tmp = ready_heap[up];
      ready_heap[up] = ready_heap[i];
      ready_heap[i] = tmp;
      i = up;
    end
  endtask

  // Remove the minimum; the left child wins a tie while sifting down.
  task automatic heap_extract(output slot_t top);
    int unsigned i;
    int unsigned sm;
    int unsigned l;
    int unsigned r;
    slot_t       tmp;
    top = ready_heap[0];
    ready_count--;
    i = 0;
    if (ready_count >= 1) begin
      ready_heap[0] = ready_heap[ready_count];
      forever begin
        sm = i;
        l = 2 * i + 1;
        r = 2 * i + 2;
        if (l < ready_count && ready_heap[l].prio < ready_heap[sm].prio) sm = l;
        if (r < ready_count && ready_heap[r].prio < ready_heap[sm].prio) sm = r;
        if (sm == i) break;
        tmp = ready_heap[sm];
        ready_heap[sm] = ready_heap[i];
        ready_heap[i] = tmp;
        i = sm;
      end
    end
  endtask

  // Work out the result of one accepted request.
  task automatic schedule_request(input logic [39:0] req);
    sched_result_t res;
    slot_t         s;
    logic [31:0]   t;
    res = '0;
    res.tick_time = sched_time;
    if (req[0] == 1'(ActArrive)) begin
      res.run_pid = req[8:1];
      if (ready_count >= HeapDepth) begin
        res.status = StDropped;
      end else begin
        s.pid = req[8:1];
        s.prio = req[16:9];
        s.remaining = req[32:17];
        s.orig = req[32:17];
        s.arrival = sched_time;
        s.responded = 1'b0;
        heap_insert(s);
        res.status = StAccepted;
      end
    end else begin
      if (ready_count == 0) begin
        res.status = StIdle;
      end else begin
        heap_extract(s);
        res.status = StRan;
        res.run_pid = s.pid;
        if (!s.responded) begin
          s.responded = 1'b1;
          res.first_run = 1'b1;
          res.response_time = sched_time - s.arrival;
        end
        if (s.remaining <= 16'd1) begin
          t = sched_time + 32'd1 - s.arrival;
          res.finished = 1'b1;
          res.turnaround = t;
          res.waiting = t - 32'(s.orig);
        end else begin
          s.remaining = s.remaining - 16'd1;
          heap_insert(s);
        end
      end
      sched_time = sched_time + 32'd1;
    end
    due_results.push_back(res);
  endtask

  function automatic logic [39:0] make_arrival(input logic [7:0] pid, input logic [7:0] prio,
                                               input logic [15:0] burst);
    return {7'd0, burst, prio, pid, 1'(ActArrive)};
  endfunction

  function automatic logic [39:0] make_tick();
    return {39'd0, 1'(ActTick)};
  endfunction

  // Driver: present requests at the falling edge, with random idle cycles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= request_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk_i) begin
    sched_result_t act;
    sched_result_t exp_res;
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) schedule_request(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        act = sched_result_t'(m_axis_tdata[139:0]);
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, act);
          error_count++;
        end else begin
          exp_res = due_results.pop_front();
          if (act.status !== exp_res.status)
            $display("%0t: status exp %0d got %0d", $time, exp_res.status, act.status);
          if (act.run_pid !== exp_res.run_pid)
            $display("%0t: run_pid exp %0d got %0d", $time, exp_res.run_pid, act.run_pid);
          if (act.tick_time !== exp_res.tick_time)
            $display("%0t: tick_time exp %0d got %0d", $time, exp_res.tick_time,
                     act.tick_time);
          if (act.first_run !== exp_res.first_run)
            $display("%0t: first_run exp %0d got %0d", $time, exp_res.first_run,
                     act.first_run);
          if (act.response_time !== exp_res.response_time)
            $display("%0t: response_time exp %0d got %0d", $time, exp_res.response_time,
                     act.response_time);
          if (act.finished !== exp_res.finished)
            $display("%0t: finished exp %0d got %0d", $time, exp_res.finished,
                     act.finished);
          if (act.turnaround !== exp_res.turnaround)
            $display("%0t: turnaround exp %0d got %0d", $time, exp_res.turnaround,
                     act.turnaround);
          if (act.waiting !== exp_res.waiting)
            $display("%0t: waiting exp %0d got %0d", $time, exp_res.waiting, act.waiting);
          if (act !== exp_res) error_count++;
        end
      end
    end
  end

  // Random arrival with mostly short bursts so that processes finish.
  function automatic logic [39:0] random_arrival();
    logic [15:0] burst;
    case ($urandom_range(9))
      0:       burst = 16'($urandom_range(65535));
      1:       burst = 16'd0;
      default: burst = 16'($urandom_range(1, 6));
    endcase
    return make_arrival(8'($urandom), 8'($urandom_range(0, 1) ? $urandom_range(7) : $urandom),
                        burst);
  endfunction

  initial begin
    int phase;
    int n;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    error_count = 0;
    ready_count = 0;
    sched_time = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    stimulus_done = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: idle tick, field extremes, zero burst, ties, preemption.
    request_queue.push_back(make_tick());
    request_queue.push_back(make_arrival(8'hff, 8'hff, 16'hffff));
    request_queue.push_back(make_arrival(8'h00, 8'h00, 16'd0));
    request_queue.push_back(make_arrival(8'haa, 8'h55, 16'd1));
    request_queue.push_back(make_arrival(8'h55, 8'h55, 16'd2));
    request_queue.push_back(make_arrival(8'h0f, 8'haa, 16'h8000));
    for (int i = 0; i < 5; i++) request_queue.push_back(make_tick());
    request_queue.push_back(make_arrival(8'h11, 8'h01, 16'd3));
    for (int i = 0; i < 4; i++) request_queue.push_back(make_tick());

    // Random phases with different idling profiles; one overfills the heap.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      if (phase == 2) begin
        // Overfill the heap to exercise dropped arrivals.
        for (int i = 0; i < HeapDepth + 6; i++) request_queue.push_back(random_arrival());
        for (int i = 0; i < 10; i++) request_queue.push_back(make_tick());
      end
      for (n = 0; n < 120; n++)
        request_queue.push_back($urandom_range(1) ? make_tick() : random_arrival());
      while (request_queue.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    end

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("preemptive_priority_scheduler_unit verification clean");
    end else begin
      $display("preemptive_priority_scheduler_unit verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("preemptive_priority_scheduler_unit verification failed");
    $finish;
  end

endmodule
